FILE: rtl/tfs_pkg.sv
// Shared constants, codes and types of the three-level feedback scheduler.
`default_nettype none

package tfs_pkg;

    localparam int PID_W     = 3;
    localparam int NUM_PROCS = 2 ** PID_W;
    localparam int QPOS_W    = PID_W;
    localparam int CNT_W     = $clog2(NUM_PROCS + 1);
    localparam int SLICE_W   = 8;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int NUM_LVLS  = 3;
    localparam int LVL_W     = 2;
    localparam int QADDR_W   = LVL_W + QPOS_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [REQ_W-1:0] REQ_ADMIT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SCHED = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NORUN = 2'd2;

    localparam logic [LVL_W-1:0] LVL_HIGH = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_LOW  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MID_SLICE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_SLICE = 1'b1;

    localparam logic [SLICE_W-1:0] MID_SLICE_RST = 8'd4;
    localparam logic [SLICE_W-1:0] LOW_SLICE_RST = 8'd8;

    typedef struct packed {
        logic             push;
        logic [LVL_W-1:0] push_lvl;
        logic             pop;
        logic [LVL_W-1:0] pop_lvl;
    } t_qcmd;

    typedef struct packed {
        logic [NUM_LVLS-1:0][QPOS_W-1:0] head;
        logic [NUM_LVLS-1:0][CNT_W-1:0]  cnt;
    } t_qstat;

endpackage

`default_nettype wire

FILE: rtl/tfs_ifs.sv
// Request, response and configuration channel interfaces of the scheduler.
`default_nettype none

interface tfs_req_if import tfs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [PID_W-1:0]   proc_id;
    logic [SLICE_W-1:0] init_slice;

    modport source (output valid, output req_type, output proc_id, output init_slice,
                    input ready);
    modport sink   (input valid, input req_type, input proc_id, input init_slice,
                    output ready);
endinterface

interface tfs_rsp_if import tfs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PID_W-1:0]    ready_pid;
    logic [SLICE_W-1:0]  ready_slice;
    logic                ready_valid;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output ready_pid, output ready_slice,
                    output ready_valid, output status, input ready);
    modport sink   (input valid, input ready_pid, input ready_slice,
                    input ready_valid, input status, output ready);
endinterface

interface tfs_cfg_if import tfs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] idx;
    logic [SLICE_W-1:0]   data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/three_level_feedback_scheduler_top.sv
// Three-level feedback scheduler: admit, tick and schedule requests over three process queues.
// One result item comes back for every request item. The queue entries sit in one 32x3
// memory and the slice counts in an 8x8 memory, both with one registered read port, so
// the sequencer visits one queue entry at a time: queue read, slice read, then decide
// and write back. A schedule scans the levels in order and repeats the scan from the
// high level after a pass that changed anything. A new request is taken while a
// finished result still waits in the output register. No clearing pass follows reset:
// fill counts guard every queue read.
`default_nettype none

module three_level_feedback_scheduler_top import tfs_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tfs_req_if.sink    i_req,
    tfs_rsp_if.source  o_rsp,
    tfs_cfg_if.sink    i_cfg
);

    localparam int QMEM_DEPTH = 2 ** QADDR_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TICK = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_Q    = 3'd5;
    localparam logic [2:0] S_S    = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_changed, n_changed;
    logic [PID_W-1:0]    r_cur_pid, n_cur_pid;
    logic [PID_W-1:0]    r_run_pid, n_run_pid;
    logic                r_run_valid, n_run_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [SLICE_W-1:0]  r_mid_slice;
    logic [SLICE_W-1:0]  r_low_slice;

    logic                r_o_valid;
    logic [PID_W-1:0]    r_o_pid;
    logic [SLICE_W-1:0]  r_o_slice;
    logic                r_o_rv;
    logic [STATUS_W-1:0] r_o_status;

    logic [PID_W-1:0]    r_qmem [QMEM_DEPTH];
    logic [PID_W-1:0]    r_qrd;
    logic [SLICE_W-1:0]  r_smem [NUM_PROCS];
    logic [SLICE_W-1:0]  r_srd;

    logic                q_we;
    logic [QADDR_W-1:0]  q_waddr;
    logic [PID_W-1:0]    q_wdata;
    logic [QADDR_W-1:0]  q_raddr;
    logic                s_we;
    logic [PID_W-1:0]    s_waddr;
    logic [SLICE_W-1:0]  s_wdata;
    logic [PID_W-1:0]    s_raddr;

    t_qcmd               qcmd;
    t_qstat              qstat;

    logic                req_fire;
    logic                out_free;
    logic                load_out;
    logic [LVL_W-1:0]    dst_lvl;
    logic [CNT_W-1:0]    sel_cnt;
    logic [QPOS_W-1:0]   sel_head;
    logic [CNT_W-1:0]    dst_cnt;
    logic [QPOS_W-1:0]   dst_head;
    logic [CNT_W-1:0]    hi_cnt;
    logic [QPOS_W-1:0]   hi_head;

    tfs_qctl u_qctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (qcmd),
        .o_stat  (qstat)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_fire    = i_req.valid && (r_state == S_IDLE);
    assign out_free    = !r_o_valid || o_rsp.ready;

    assign dst_lvl  = (r_lvl == LVL_HIGH) ? LVL_MID : LVL_LOW;
    assign sel_cnt  = qstat.cnt[r_lvl];
    assign sel_head = qstat.head[r_lvl];
    assign dst_cnt  = qstat.cnt[dst_lvl];
    assign dst_head = qstat.head[dst_lvl];
    assign hi_cnt   = qstat.cnt[LVL_HIGH];
    assign hi_head  = qstat.head[LVL_HIGH];

    always_comb begin
        n_state     = r_state;
        n_lvl       = r_lvl;
        n_idx       = r_idx;
        n_changed   = r_changed;
        n_cur_pid   = r_cur_pid;
        n_run_pid   = r_run_pid;
        n_run_valid = r_run_valid;
        n_status    = r_status;
        q_we        = 1'b0;
        q_waddr     = {dst_lvl, dst_head + dst_cnt[QPOS_W-1:0]};
        q_wdata     = r_cur_pid;
        q_raddr     = {r_lvl, sel_head + r_idx[QPOS_W-1:0]};
        s_we        = 1'b0;
        s_waddr     = r_cur_pid;
        s_wdata     = r_low_slice;
        s_raddr     = r_run_pid;
        qcmd        = '0;
        load_out    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_status = ST_OK;
                    case (i_req.req_type)
                        REQ_ADMIT: begin
                            n_state = S_RD;
                            if (hi_cnt < CNT_W'(NUM_PROCS)) begin
                                q_we          = 1'b1;
                                q_waddr       = {LVL_HIGH, hi_head + hi_cnt[QPOS_W-1:0]};
                                q_wdata       = i_req.proc_id;
                                s_we          = 1'b1;
                                s_waddr       = i_req.proc_id;
                                s_wdata       = i_req.init_slice;
                                qcmd.push     = 1'b1;
                                qcmd.push_lvl = LVL_HIGH;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        REQ_TICK: begin
                            n_state = r_run_valid ? S_TICK : S_RD;
                        end
                        REQ_SCHED: begin
                            n_state   = S_CHK;
                            n_lvl     = LVL_HIGH;
                            n_idx     = '0;
                            n_changed = 1'b0;
                        end
                        default: begin
                            n_state = S_RD;
                        end
                    endcase
                end
            end
            S_TICK: begin
                if (r_srd != '0) begin
                    s_we    = 1'b1;
                    s_waddr = r_run_pid;
                    s_wdata = r_srd - SLICE_W'(1);
                end
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_CHK: begin
                if (r_idx < sel_cnt) begin
                    n_state = S_Q;
                end else if (r_lvl != LVL_LOW) begin
                    n_lvl = r_lvl + LVL_W'(1);
                    n_idx = '0;
                end else if (r_changed) begin
                    n_lvl     = LVL_HIGH;
                    n_idx     = '0;
                    n_changed = 1'b0;
                end else begin
                    n_run_valid = 1'b0;
                    n_run_pid   = '0;
                    n_status    = ST_NORUN;
                    n_state     = S_RD;
                end
            end
            S_Q: begin
                n_cur_pid = r_qrd;
                s_raddr   = r_qrd;
                n_state   = S_S;
            end
            S_S: begin
                n_state = S_CHK;
                if (r_srd != '0) begin
                    n_run_pid   = r_cur_pid;
                    n_run_valid = 1'b1;
                    n_status    = ST_OK;
                    n_state     = S_RD;
                end else if (r_lvl == LVL_LOW) begin
                    if (r_low_slice != '0) begin
                        s_we      = 1'b1;
                        n_changed = 1'b1;
                    end
                    n_idx = r_idx + CNT_W'(1);
                end else if (dst_cnt < CNT_W'(NUM_PROCS)) begin
                    s_we          = 1'b1;
                    s_wdata       = (r_lvl == LVL_HIGH) ? r_mid_slice : r_low_slice;
                    q_we          = 1'b1;
                    qcmd.push     = 1'b1;
                    qcmd.push_lvl = dst_lvl;
                    qcmd.pop      = 1'b1;
                    qcmd.pop_lvl  = r_lvl;
                    n_changed     = 1'b1;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lvl       <= LVL_HIGH;
            r_idx       <= '0;
            r_changed   <= 1'b0;
            r_run_pid   <= '0;
            r_run_valid <= 1'b0;
            r_mid_slice <= MID_SLICE_RST;
            r_low_slice <= LOW_SLICE_RST;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lvl       <= n_lvl;
            r_idx       <= n_idx;
            r_changed   <= n_changed;
            r_run_pid   <= n_run_pid;
            r_run_valid <= n_run_valid;
            if (i_cfg.valid) begin
                case (i_cfg.idx)
                    CFG_MID_SLICE: r_mid_slice <= i_cfg.data;
                    CFG_LOW_SLICE: r_low_slice <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_pid <= n_cur_pid;
        r_status  <= n_status;
        if (load_out) begin
            r_o_pid    <= r_run_valid ? r_run_pid : '0;
            r_o_slice  <= r_run_valid ? r_srd : '0;
            r_o_rv     <= r_run_valid;
            r_o_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_qmem[q_waddr] <= q_wdata;
        end
        r_qrd <= r_qmem[q_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_smem[s_waddr] <= s_wdata;
        end
        r_srd <= r_smem[s_raddr];
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.ready_pid   = r_o_pid;
    assign o_rsp.ready_slice = r_o_slice;
    assign o_rsp.ready_valid = r_o_rv;
    assign o_rsp.status      = r_o_status;

endmodule

`default_nettype wire

FILE: rtl/tfs_qctl.sv
// Head pointers and fill counts of the three circular process queues.
`default_nettype none

module tfs_qctl import tfs_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_qcmd  i_cmd,
    output t_qstat      o_stat
);

    logic [NUM_LVLS-1:0][QPOS_W-1:0] r_head;
    logic [NUM_LVLS-1:0][QPOS_W-1:0] n_head;
    logic [NUM_LVLS-1:0][CNT_W-1:0]  r_cnt;
    logic [NUM_LVLS-1:0][CNT_W-1:0]  n_cnt;

    always_comb begin
        n_head = r_head;
        n_cnt  = r_cnt;
        for (int l = 0; l < NUM_LVLS; l++) begin
            if (i_cmd.pop && i_cmd.pop_lvl == LVL_W'(l)) begin
                n_head[l] = r_head[l] + QPOS_W'(1);
                n_cnt[l]  = n_cnt[l] - CNT_W'(1);
            end
            if (i_cmd.push && i_cmd.push_lvl == LVL_W'(l)) begin
                n_cnt[l] = n_cnt[l] + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
        end
    end

    assign o_stat.head = r_head;
    assign o_stat.cnt  = r_cnt;

endmodule

`default_nettype wire

FILE: rtl/tfs_checker.sv
// Port-level assertions of the scheduler top level and the bind that attaches them.
`default_nettype none

module tfs_checker import tfs_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_req_valid,
    input wire logic                i_req_ready,
    input wire logic                i_rsp_valid,
    input wire logic                i_rsp_ready,
    input wire logic [PID_W-1:0]    i_rsp_pid,
    input wire logic [SLICE_W-1:0]  i_rsp_slice,
    input wire logic                i_rsp_rv,
    input wire logic [STATUS_W-1:0] i_rsp_status
);

    logic [1:0] r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(i_req_valid && i_req_ready)
                             - 2'(i_rsp_valid && i_rsp_ready);
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_pend != 2'd0)
        else $error("result item without a pending request item");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two request items in flight");

    a_norun_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_NORUN |->
            !i_rsp_rv && i_rsp_pid == '0 && i_rsp_slice == '0)
        else $error("no-runnable result reports a process");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable({i_rsp_pid, i_rsp_slice, i_rsp_rv, i_rsp_status}))
        else $error("stalled result item changed");

endmodule

bind three_level_feedback_scheduler_top tfs_checker u_tfs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_pid    (o_rsp.ready_pid),
    .i_rsp_slice  (o_rsp.ready_slice),
    .i_rsp_rv     (o_rsp.ready_valid),
    .i_rsp_status (o_rsp.status)
);

`default_nettype wire

FILE: sim/three_level_feedback_scheduler_top_tb.sv
// Self-checking testbench for the three-level feedback scheduler top level.
`timescale 1ns / 100ps

module three_level_feedback_scheduler_top_tb;
    import tfs_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int IDLE_LIMIT  = 5000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 175;
    localparam int NUM_PHASES  = 7;

    typedef struct packed {
        logic [REQ_W-1:0]   kind;
        logic [PID_W-1:0]   pid;
        logic [SLICE_W-1:0] slice;
    } t_sched_req;

    typedef struct packed {
        logic [PID_W-1:0]    pid;
        logic [SLICE_W-1:0]  slice;
        logic                valid;
        logic [STATUS_W-1:0] status;
    } t_grant;

    logic i_clk;
    logic i_rst_n;

    tfs_req_if req_if ();
    tfs_rsp_if rsp_if ();
    tfs_cfg_if cfg_if ();

    three_level_feedback_scheduler_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // scheduler shadow state
    logic [PID_W-1:0]   lvl_ent [NUM_LVLS][NUM_PROCS];
    int                 lvl_cnt [NUM_LVLS];
    logic [SLICE_W-1:0] slice_tab [NUM_PROCS];
    logic [PID_W-1:0]   run_pid;
    logic               run_valid;
    logic [SLICE_W-1:0] demote_mid_slice;
    logic [SLICE_W-1:0] demote_low_slice;
    logic [PID_W-1:0]   pick_pid;
    bit                 pass_changed;

    t_sched_req request_backlog [$];
    t_grant     pending_grants [$];
    t_sched_req cur_req;

    int  n_queued;
    int  n_accepted;
    int  n_results;
    int  n_errors;
    int  n_cfg_writes;
    int  n_full_seen;
    int  n_norun_seen;
    int  idle_cycles;
    int  gap_left;
    int  stall_left;
    int  long_left;
    int  hold_trig;
    int  hold_seen;
    bit  drv_holding;
    bit  drv_burst;
    bit  mon_burst;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit demote_scan(input int lv, input logic [SLICE_W-1:0] fresh);
        int i;
        int k;
        logic [PID_W-1:0] p;
        i = 0;
        while (i < lvl_cnt[lv]) begin
            p = lvl_ent[lv][i];
            if (slice_tab[p] != 0) begin
                pick_pid = p;
                return 1'b1;
            end
            if (lvl_cnt[lv+1] < NUM_PROCS) begin
                slice_tab[p] = fresh;
                lvl_ent[lv+1][lvl_cnt[lv+1]] = p;
                lvl_cnt[lv+1]++;
                for (k = i; k + 1 < lvl_cnt[lv]; k++)
                    lvl_ent[lv][k] = lvl_ent[lv][k+1];
                lvl_cnt[lv]--;
                pass_changed = 1'b1;
            end else begin
                i++;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit refill_scan();
        int i;
        logic [PID_W-1:0] p;
        for (i = 0; i < lvl_cnt[LVL_LOW]; i++) begin
            p = lvl_ent[LVL_LOW][i];
            if (slice_tab[p] != 0) begin
                pick_pid = p;
                return 1'b1;
            end
            if (demote_low_slice != 0) begin
                slice_tab[p] = demote_low_slice;
                pass_changed = 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [STATUS_W-1:0] pick_next_runner();
        int guard;
        for (guard = 0; guard < 256; guard++) begin
            pass_changed = 1'b0;
            if (demote_scan(LVL_HIGH, demote_mid_slice) ||
                demote_scan(LVL_MID, demote_low_slice) || refill_scan()) begin
                run_pid   = pick_pid;
                run_valid = 1'b1;
                return ST_OK;
            end
            if (!pass_changed)
                break;
        end
        run_valid = 1'b0;
        run_pid   = '0;
        return ST_NORUN;
    endfunction

    function automatic t_grant advance_scheduler(input t_sched_req rq);
        t_grant g;
        g.status = ST_OK;
        case (rq.kind)
            REQ_ADMIT: begin
                if (lvl_cnt[LVL_HIGH] >= NUM_PROCS) begin
                    g.status = ST_FULL;
                end else begin
                    lvl_ent[LVL_HIGH][lvl_cnt[LVL_HIGH]] = rq.pid;
                    lvl_cnt[LVL_HIGH]++;
                    slice_tab[rq.pid] = rq.slice;
                end
            end
            REQ_TICK: begin
                if (run_valid && slice_tab[run_pid] != 0)
                    slice_tab[run_pid] = slice_tab[run_pid] - 1'b1;
            end
            REQ_SCHED: begin
                g.status = pick_next_runner();
            end
            default: begin
            end
        endcase
        g.valid = run_valid;
        g.pid   = run_valid ? run_pid : '0;
        g.slice = run_valid ? slice_tab[run_pid] : '0;
        return g;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("ERROR: result %0d %s got %0d expected %0d", n_results, what, got, want);
    endtask

    function automatic t_sched_req mk_req(input logic [REQ_W-1:0] kind,
                                          input logic [PID_W-1:0] pid,
                                          input logic [SLICE_W-1:0] slice);
        t_sched_req r;
        r.kind  = kind;
        r.pid   = pid;
        r.slice = slice;
        return r;
    endfunction

    function automatic logic [SLICE_W-1:0] draw_slice();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return SLICE_W'($urandom_range(1, 4));
        else if (r < 85)
            return 8'd255;
        return SLICE_W'($urandom_range(1, 255));
    endfunction

    task automatic push_req(input t_sched_req rq);
        request_backlog.push_back(rq);
        n_queued++;
    endtask

    task automatic queue_random(input int n);
        int made;
        int na;
        int rounds;
        int nt;
        made = 0;
        while (made < n) begin
            if ($urandom_range(0, 99) < 8) begin
                push_req(mk_req(REQ_W'($urandom_range(0, 3)), PID_W'($urandom_range(0, 7)),
                                SLICE_W'($urandom_range(1, 255))));
                made++;
            end else begin
                na = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, 1);
                repeat (na) begin
                    push_req(mk_req(REQ_ADMIT, PID_W'($urandom_range(0, 7)), draw_slice()));
                    made++;
                end
                rounds = $urandom_range(1, 4);
                repeat (rounds) begin
                    push_req(mk_req(REQ_SCHED, PID_W'($urandom_range(0, 7)),
                                    SLICE_W'($urandom_range(0, 255))));
                    made++;
                    nt = $urandom_range(0, 5);
                    repeat (nt) begin
                        push_req(mk_req(REQ_TICK, PID_W'($urandom_range(0, 7)),
                                        SLICE_W'($urandom_range(0, 255))));
                        made++;
                    end
                end
            end
        end
    endtask

    task automatic queue_directed();
        push_req(mk_req(REQ_TICK, 3'd0, 8'd0));
        push_req(mk_req(REQ_SCHED, 3'd0, 8'd0));
        push_req(mk_req(REQ_UNKNOWN, 3'd5, 8'hAA));
        push_req(mk_req(REQ_ADMIT, 3'd0, 8'd1));
        push_req(mk_req(REQ_ADMIT, 3'd7, 8'd255));
        push_req(mk_req(REQ_ADMIT, 3'd7, 8'd2));
        push_req(mk_req(REQ_SCHED, 3'd0, 8'd0));
        push_req(mk_req(REQ_TICK, 3'd0, 8'd0));
        push_req(mk_req(REQ_SCHED, 3'd0, 8'd0));
        push_req(mk_req(REQ_TICK, 3'd0, 8'd0));
        push_req(mk_req(REQ_TICK, 3'd0, 8'd0));
        push_req(mk_req(REQ_SCHED, 3'd0, 8'd0));
        push_req(mk_req(REQ_UNKNOWN, 3'd2, 8'h55));
        push_req(mk_req(REQ_ADMIT, 3'd5, 8'd1));
        push_req(mk_req(REQ_ADMIT, 3'd1, 8'd128));
        push_req(mk_req(REQ_ADMIT, 3'd2, 8'd64));
        push_req(mk_req(REQ_ADMIT, 3'd3, 8'd3));
        push_req(mk_req(REQ_ADMIT, 3'd4, 8'd1));
        push_req(mk_req(REQ_ADMIT, 3'd6, 8'd1));
        push_req(mk_req(REQ_ADMIT, 3'd0, 8'd4));
        push_req(mk_req(REQ_ADMIT, 3'd7, 8'd85));
        push_req(mk_req(REQ_ADMIT, 3'd6, 8'd200));
        push_req(mk_req(REQ_SCHED, 3'd0, 8'd0));
        push_req(mk_req(REQ_TICK, 3'd0, 8'd0));
        push_req(mk_req(REQ_SCHED, 3'd0, 8'd0));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SLICE_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.idx   <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == CFG_MID_SLICE)
            demote_mid_slice = val;
        else
            demote_low_slice = val;
        n_cfg_writes++;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (n_results != n_queued);
        repeat (30) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            drv_holding = 1'b0;
            gap_left    = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                pending_grants.push_back(advance_scheduler(cur_req));
                n_accepted++;
                drv_holding = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    drv_burst = !drv_burst;
                gap_left = drv_burst ? 0 : $urandom_range(0, 13);
            end
            if (drv_holding) begin
            end else if (gap_left > 0) begin
                gap_left--;
                req_if.valid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
                cur_req = request_backlog.pop_front();
                req_if.req_type   <= cur_req.kind;
                req_if.proc_id    <= cur_req.pid;
                req_if.init_slice <= cur_req.slice;
                req_if.valid      <= 1'b1;
                drv_holding = 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_grant want;
        bit got;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
            long_left  = 0;
        end else begin
            got = rsp_if.valid && rsp_if.ready;
            if (got) begin
                n_results++;
                if (rsp_if.status == ST_FULL)
                    n_full_seen++;
                if (rsp_if.status == ST_NORUN)
                    n_norun_seen++;
                if (pending_grants.size() == 0) begin
                    report_mismatch("with nothing awaited, status", int'(rsp_if.status), 0);
                end else begin
                    want = pending_grants.pop_front();
                    if (rsp_if.ready_pid !== want.pid)
                        report_mismatch("ready_pid", int'(rsp_if.ready_pid), int'(want.pid));
                    if (rsp_if.ready_slice !== want.slice)
                        report_mismatch("ready_slice", int'(rsp_if.ready_slice),
                                        int'(want.slice));
                    if (rsp_if.ready_valid !== want.valid)
                        report_mismatch("ready_valid", int'(rsp_if.ready_valid),
                                        int'(want.valid));
                    if (rsp_if.status !== want.status)
                        report_mismatch("status", int'(rsp_if.status), int'(want.status));
                end
                if ($urandom_range(0, 39) == 0)
                    mon_burst = !mon_burst;
                stall_left = mon_burst ? 0 : $urandom_range(0, 13);
            end
            if (hold_trig != hold_seen) begin
                hold_seen = hold_trig;
                long_left = LONG_HOLD;
            end
            if (long_left > 0) begin
                long_left--;
                rsp_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        logic [SLICE_W-1:0] mid_set [NUM_PHASES];
        logic [SLICE_W-1:0] low_set [NUM_PHASES];
        int ph;
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        req_if.valid      = 1'b0;
        req_if.req_type   = REQ_ADMIT;
        req_if.proc_id    = '0;
        req_if.init_slice = '0;
        rsp_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.idx        = CFG_MID_SLICE;
        cfg_if.data       = '0;
        n_queued = 0; n_accepted = 0; n_results = 0; n_errors = 0;
        n_cfg_writes = 0; n_full_seen = 0; n_norun_seen = 0; idle_cycles = 0;
        hold_trig = 0; hold_seen = 0; drv_burst = 1'b0; mon_burst = 1'b0;
        gap_left = 0; stall_left = 0; long_left = 0; drv_holding = 1'b0;
        for (int l = 0; l < NUM_LVLS; l++)
            lvl_cnt[l] = 0;
        for (int p = 0; p < NUM_PROCS; p++)
            slice_tab[p] = '0;
        run_pid = '0;
        run_valid = 1'b0;
        demote_mid_slice = MID_SLICE_RST;
        demote_low_slice = LOW_SLICE_RST;
        mid_set = '{8'd1, 8'd255, MID_SLICE_RST, 8'd1, 8'd255, 8'd0, 8'd0};
        low_set = '{8'd1, 8'd255, LOW_SLICE_RST, 8'd255, 8'd1, 8'd0, 8'd0};
        mid_set[5] = SLICE_W'($urandom_range(1, 255));
        low_set[5] = SLICE_W'($urandom_range(1, 255));
        mid_set[6] = SLICE_W'($urandom_range(1, 8));
        low_set[6] = SLICE_W'($urandom_range(1, 8));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(CFG_MID_SLICE, mid_set[ph]);
            write_reg(CFG_LOW_SLICE, low_set[ph]);
            cfg_if.valid <= 1'b0;
            if (ph == 3)
                hold_trig <= hold_trig + 1;
            if (ph == 0)
                queue_directed();
            else
                queue_random(PHASE_ITEMS);
            wait_drained();
        end

        if (pending_grants.size() != 0)
            report_mismatch("awaited results left over", pending_grants.size(), 0);
        $display("Summary: %0d request items checked over %0d register writes in %0d phases",
                 n_results, n_cfg_writes, NUM_PHASES);
        $display("Summary: %0d admits rejected as full, %0d schedules with nothing runnable",
                 n_full_seen, n_norun_seen);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tfs_pkg.sv
rtl/tfs_ifs.sv
rtl/tfs_qctl.sv
rtl/three_level_feedback_scheduler_top.sv
rtl/tfs_checker.sv
sim/three_level_feedback_scheduler_top_tb.sv
